### rtl/bcd_real_time_clock_registers_defines.svh
// Assertion macros used by the checker file of the BCD real-time clock.
`ifndef BCD_REAL_TIME_CLOCK_REGISTERS_DEFINES_SVH
`define BCD_REAL_TIME_CLOCK_REGISTERS_DEFINES_SVH

// Checked only while out of reset.
`define RTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bcdrtc_pkg.sv
// Types, constants and BCD helpers for the BCD real-time clock.
package bcdrtc_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [4:0] HALF_DAY  = 5'd12;
  localparam logic [2:0] WDAY_MAX  = 3'd6;
  localparam logic [7:0] LOW_NIBBLE = 8'h0F;

  // control register bits
  localparam int CTL_RUN  = 7;
  localparam int CTL_HR24 = 6;
  localparam int CTL_PM   = 5;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } act_t;

  typedef enum logic [2:0] {
    REG_CONTROL = 3'd0,
    REG_SECONDS = 3'd1,
    REG_MINUTES = 3'd2,
    REG_HOURS   = 3'd3,
    REG_WEEKDAY = 3'd4
  } reg_sel_t;

  typedef struct packed {
    logic [5:0] sec_count;
    logic [5:0] min_count;
    logic [4:0] hour_count;
    logic [2:0] day_of_week;
    logic [1:0] quarter_phase;
    logic       started;
    logic [7:0] control_reg;
    logic [7:0] sec_reg;
    logic [7:0] min_reg;
    logic [7:0] hour_reg;
    logic [7:0] wday_reg;
  } rtc_state_t;

  typedef struct packed {
    logic week;
    logic day;
    logic hour;
    logic minute;
    logic second;
    logic half;
    logic quarter;
  } rtc_flags_t;

  // binary 0..63 to packed BCD
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] ones;
    tens = (v >= 6'd60) ? 3'd6 :
           (v >= 6'd50) ? 3'd5 :
           (v >= 6'd40) ? 3'd4 :
           (v >= 6'd30) ? 3'd3 :
           (v >= 6'd20) ? 3'd2 :
           (v >= 6'd10) ? 3'd1 : 3'd0;
    ones = v - 6'(tens) * 6'd10;
    return {1'b0, tens, ones[3:0]};
  endfunction

  // high nibble * 10 + low nibble, no digit check
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    return 8'({4'b0, v[7:4]} * 8'd10) + (v & LOW_NIBBLE);
  endfunction

  // v mod 12 by reciprocal multiply, exact for any 8-bit v
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [8:0]  qx12;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd171;
    q    = prod[15:11];
    qx12 = 9'(q) * 9'd12;
    rem  = v - qx12[7:0];
    return rem[3:0];
  endfunction

endpackage

### rtl/bcdrtc_update.sv
// Next-state and flag logic for one word: tick advance or register write.
module bcdrtc_update (
  input  bcdrtc_pkg::rtc_state_t state_i,
  input  logic                   action_i,
  input  logic [2:0]             reg_select_i,
  input  logic [7:0]             write_data_i,
  output bcdrtc_pkg::rtc_state_t state_o,
  output bcdrtc_pkg::rtc_flags_t flags_o
);
  import bcdrtc_pkg::*;

  logic       wr_hit;
  logic [7:0] sec_dec, min_dec, hour_dec;
  logic [4:0] hour_12, hour_load;
  logic [7:0] hour_sum;
  logic [1:0] phase_n;
  logic       sec_wrap, min_wrap, hour_wrap;
  logic [4:0] hour_mod;

  // decode path for register writes
  always_comb begin
    state_o = state_i;
    wr_hit  = 1'b1;
    case (reg_sel_t'(reg_select_i))
      REG_CONTROL: state_o.control_reg = write_data_i;
      REG_SECONDS: state_o.sec_reg     = write_data_i;
      REG_MINUTES: state_o.min_reg     = write_data_i;
      REG_HOURS:   state_o.hour_reg    = write_data_i;
      REG_WEEKDAY: state_o.wday_reg    = write_data_i;
      default:     wr_hit              = 1'b0;
    endcase
    sec_dec  = from_bcd(state_o.sec_reg);
    min_dec  = from_bcd(state_o.min_reg);
    hour_dec = from_bcd(state_o.hour_reg);
    hour_12  = {1'b0, mod12(hour_dec)};
    if (state_o.control_reg[CTL_HR24]) begin
      hour_sum = hour_dec;
    end else if (state_o.control_reg[CTL_PM]) begin
      hour_sum = 8'(hour_12) + 8'(HALF_DAY);
    end else begin
      hour_sum = 8'(hour_12);
    end
    hour_load = (hour_sum > 8'(HOUR_MAX)) ? HOUR_MAX : hour_sum[4:0];

    // tick path
    phase_n   = state_i.quarter_phase + 2'd1;
    sec_wrap  = (phase_n == 2'd0) && (state_i.sec_count >= SEC_MAX);
    min_wrap  = sec_wrap && (state_i.min_count >= MIN_MAX);
    hour_wrap = min_wrap && (state_i.hour_count >= HOUR_MAX);
    hour_mod  = 5'd0;
    flags_o   = '0;

    if (action_i == ACT_WRITE) begin
      if (!wr_hit) begin
        state_o = state_i;
      end else begin
        state_o.sec_count  = (sec_dec > 8'(SEC_MAX)) ? SEC_MAX : sec_dec[5:0];
        state_o.min_count  = (min_dec > 8'(MIN_MAX)) ? MIN_MAX : min_dec[5:0];
        state_o.hour_count = hour_load;
      end
    end else begin
      state_o = state_i;
      if (state_i.control_reg[CTL_RUN]) begin
        state_o.quarter_phase = phase_n;
        if (phase_n == 2'd0) begin
          state_o.sec_count = sec_wrap ? 6'd0 : state_i.sec_count + 6'd1;
          if (sec_wrap) begin
            state_o.min_count = min_wrap ? 6'd0 : state_i.min_count + 6'd1;
          end
          if (min_wrap) begin
            state_o.hour_count = hour_wrap ? 5'd0 : state_i.hour_count + 5'd1;
          end
          if (hour_wrap) begin
            state_o.day_of_week = (state_i.day_of_week >= WDAY_MAX) ? 3'd0 :
                                  state_i.day_of_week + 3'd1;
          end
        end
        // readout refresh
        state_o.sec_reg = to_bcd(state_o.sec_count);
        state_o.min_reg = to_bcd(state_o.min_count);
        if (state_i.control_reg[CTL_HR24]) begin
          state_o.hour_reg = to_bcd({1'b0, state_o.hour_count});
        end else begin
          state_o.control_reg[CTL_PM] = (state_o.hour_count >= HALF_DAY);
          hour_mod = (state_o.hour_count >= HALF_DAY) ?
                     state_o.hour_count - HALF_DAY : state_o.hour_count;
          state_o.hour_reg = to_bcd({1'b0, hour_mod});
        end
        state_o.wday_reg = to_bcd({3'b0, state_o.day_of_week});

        flags_o.quarter = 1'b1;
        flags_o.half    = !phase_n[0];
        flags_o.second  = (phase_n == 2'd0);
        flags_o.minute  = sec_wrap;
        flags_o.hour    = min_wrap;
        flags_o.day     = hour_wrap;
        flags_o.week    = hour_wrap;
        if (!state_i.started) begin
          flags_o         = '1;
          state_o.started = 1'b1;
        end
      end
    end
  end

endmodule

### rtl/bcd_real_time_clock_registers.sv
// Top level of the BCD real-time clock: input register, clock state, result register.
//
// Input channel (in_*): one word per event. in_tuser is the action, 0 for a
// quarter-second tick, 1 for a register write; in_tdata carries the register
// select and the write byte. Result channel (out_*): one word per input word
// with the five readout registers as they stand after the event and the seven
// interrupt flags that event raised (all zero for writes and stopped ticks).
// A word accepted on in_* sits in the input register, moves through the update
// logic and is loaded into the result register and shown on out_* once that
// register is free or its word is being taken.
// One word per cycle is sustained while out_tready stays high; the only loop is
// the registered state update between the input and result registers.
// Reset (rst_n low, synchronous) clears the time counters, the quarter phase,
// the started bit and all readout/control registers, and drops both valids.
// When out_tready is low the result holds; the input register still takes one
// more word, after which in_tready falls until the result is taken.
module bcd_real_time_clock_registers (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] reg_select, [10:3] write_data, [15:11] zero
  input  logic [bcdrtc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] seconds_bcd, [15:8] minutes_bcd, [23:16] hours_bcd,
  // [31:24] weekday_bcd, [39:32] control_byte, [40] flag_quarter,
  // [41] flag_half, [42] flag_second, [43] flag_minute, [44] flag_hour,
  // [45] flag_day, [46] flag_week, [47] zero
  output logic [bcdrtc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bcdrtc_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic        in_action_r;
  logic [2:0]  in_sel_r;
  logic [7:0]  in_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  rtc_state_t  state_r, state_nxt;
  rtc_flags_t  flags;
  logic        advance;
  logic        in_fire;

  // word moves from input register to result register
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  bcdrtc_update u_update (
    .state_i      (state_r),
    .action_i     (in_action_r),
    .reg_select_i (in_sel_r),
    .write_data_i (in_data_r),
    .state_o      (state_nxt),
    .flags_o      (flags)
  );

  always_comb begin
    in_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_data_nxt  = {1'b0, flags.week, flags.day, flags.hour, flags.minute,
                     flags.second, flags.half, flags.quarter,
                     state_nxt.control_reg, state_nxt.wday_reg,
                     state_nxt.hour_reg, state_nxt.min_reg, state_nxt.sec_reg};
  end

  // control and clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_action_r <= in_tuser;
      in_sel_r    <= in_tdata[2:0];
      in_data_r   <= in_tdata[10:3];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/bcdrtc_checker.sv
// Port-level checks for the BCD real-time clock, bound to the top level.
`include "bcd_real_time_clock_registers_defines.svh"

module bcdrtc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [bcdrtc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bcdrtc_pkg::*;

  `RTC_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `RTC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `RTC_ASSERT(a_half_needs_quarter, out_tvalid && out_tdata[41] |-> out_tdata[40], "half flag without quarter flag")
  `RTC_ASSERT(a_minute_needs_second, out_tvalid && out_tdata[43] |-> out_tdata[42], "minute flag without second flag")
  `RTC_ASSERT(a_day_week_pair, out_tvalid |-> out_tdata[45] == out_tdata[46], "day and week flags differ")

endmodule

bind bcd_real_time_clock_registers bcdrtc_checker u_bcdrtc_checker (.*);

### tb/bcd_real_time_clock_registers_tb.sv
// Self-checking testbench for the BCD real-time clock against a clock predictor.
`timescale 1ns / 1ps

module bcd_real_time_clock_registers_tb;
  import bcdrtc_pkg::*;

  // select codes beyond the weekday register; the block ignores these writes
  localparam logic [2:0] SEL_SPARE_FIRST = 3'd5;
  localparam logic [2:0] SEL_SPARE_MID   = 3'd6;
  localparam logic [2:0] SEL_SPARE_LAST  = 3'd7;

  localparam int RANDOM_TARGET = 550;  // least number of events queued, directed included
  localparam int IDLE_LIMIT    = 1000; // cycles with no word moving on either side
  localparam int DRAIN_CYCLES  = 20;   // settle time after the last result

  // one input word: event kind, register select, raw byte
  typedef struct {
    act_t       kind;
    logic [2:0] sel;
    logic [7:0] value;
  } clock_event_t;

  // result word laid out as out_tdata[46:0]
  typedef struct packed {
    rtc_flags_t flags;
    logic [7:0] control;
    logic [7:0] weekday;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } clock_readout_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bcd_real_time_clock_registers dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Clock predictor. State starts at the reset values; reset is applied once.
  // ---------------------------------------------------------------------------
  logic [5:0] sec_cnt  = '0;
  logic [5:0] min_cnt  = '0;
  logic [4:0] hour_cnt = '0;
  logic [2:0] wday_cnt = '0;
  logic [1:0] phase_q  = '0;
  logic       ticked   = 1'b0;  // set by the first counted tick
  logic [7:0] ctl_q    = '0;
  logic [7:0] sec_q    = '0;
  logic [7:0] min_q    = '0;
  logic [7:0] hour_q   = '0;
  logic [7:0] wday_q   = '0;

  function automatic logic [7:0] bin_to_bcd(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    return ((w / 8'd10) << 4) | (w % 8'd10);
  endfunction

  // no digit check: 0xFF decodes to 165
  function automatic logic [7:0] bcd_value(input logic [7:0] v);
    return v[7:4] * 8'd10 + v[3:0];
  endfunction

  // Applies one accepted event to the predictor and returns the readout word.
  function automatic clock_readout_t apply_event(input clock_event_t ev);
    clock_readout_t r;
    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic [7:0] s;
    logic [7:0] m;
    logic [7:0] h;
    r         = '0;
    sec_wrap  = 1'b0;
    min_wrap  = 1'b0;
    hour_wrap = 1'b0;
    if (ev.kind == ACT_WRITE) begin
      if (ev.sel <= REG_WEEKDAY) begin
        case (ev.sel)
          REG_CONTROL: ctl_q  = ev.value;
          REG_SECONDS: sec_q  = ev.value;
          REG_MINUTES: min_q  = ev.value;
          REG_HOURS:   hour_q = ev.value;
          default:     wday_q = ev.value;
        endcase
        // time reloads from the readout registers, weekday counter untouched
        s = bcd_value(sec_q);
        m = bcd_value(min_q);
        h = bcd_value(hour_q);
        sec_cnt = (s > SEC_MAX) ? SEC_MAX : s[5:0];
        min_cnt = (m > MIN_MAX) ? MIN_MAX : m[5:0];
        if (!ctl_q[CTL_HR24]) begin
          h = h % HALF_DAY;
          if (ctl_q[CTL_PM])
            h = h + HALF_DAY;
        end
        hour_cnt = (h > HOUR_MAX) ? HOUR_MAX : h[4:0];
      end
    end else if (ctl_q[CTL_RUN]) begin
      phase_q = phase_q + 2'd1;
      if (phase_q == 2'd0) begin
        if (sec_cnt == SEC_MAX) begin
          sec_cnt  = '0;
          sec_wrap = 1'b1;
          if (min_cnt == MIN_MAX) begin
            min_cnt  = '0;
            min_wrap = 1'b1;
            if (hour_cnt == HOUR_MAX) begin
              hour_cnt  = '0;
              hour_wrap = 1'b1;
              wday_cnt  = (wday_cnt == WDAY_MAX) ? 3'd0 : wday_cnt + 3'd1;
            end else begin
              hour_cnt = hour_cnt + 5'd1;
            end
          end else begin
            min_cnt = min_cnt + 6'd1;
          end
        end else begin
          sec_cnt = sec_cnt + 6'd1;
        end
      end
      // readout refresh; 12-hour mode also rewrites the PM bit
      sec_q = bin_to_bcd(sec_cnt);
      min_q = bin_to_bcd(min_cnt);
      if (ctl_q[CTL_HR24]) begin
        hour_q = bin_to_bcd(hour_cnt);
      end else begin
        ctl_q[CTL_PM] = (hour_cnt >= HALF_DAY);
        hour_q        = bin_to_bcd(hour_cnt % HALF_DAY);
      end
      wday_q = bin_to_bcd({3'b000, wday_cnt});
      if (!ticked) begin
        r.flags = '1;
        ticked  = 1'b1;
      end
      r.flags.quarter = 1'b1;
      if (!phase_q[0])
        r.flags.half = 1'b1;
      if (phase_q == 2'd0) begin
        r.flags.second = 1'b1;
        if (sec_wrap)
          r.flags.minute = 1'b1;
        if (min_wrap)
          r.flags.hour = 1'b1;
        if (hour_wrap) begin
          r.flags.day  = 1'b1;
          r.flags.week = 1'b1;
        end
      end
    end
    r.seconds = sec_q;
    r.minutes = min_q;
    r.hours   = hour_q;
    r.weekday = wday_q;
    r.control = ctl_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  clock_event_t   pending_events[$];
  clock_readout_t expected_readouts[$];
  int             events_total    = 0;
  int             events_accepted = 0;
  int             mismatches      = 0;

  function automatic void push_event(input act_t kind, input logic [2:0] sel,
                                     input logic [7:0] value);
    clock_event_t ev;
    ev.kind  = kind;
    ev.sel   = sel;
    ev.value = value;
    pending_events = {pending_events, ev};
  endfunction

  // mostly a value at or one below a wrap point, otherwise any byte
  function automatic logic [7:0] near_wrap(input logic [7:0] top);
    if ($urandom_range(0, 99) < 65)
      return top - 8'($urandom_range(0, 1));
    return 8'($urandom);
  endfunction

  // tick words carry random select/data bits, which the block ignores
  function automatic void push_ticks(input int n);
    for (int i = 0; i < n; i++)
      push_event(ACT_TICK, 3'($urandom), 8'($urandom));
  endfunction

  // Idle length after a word. Mostly zero or short, now and then long, and
  // sometimes a burst of back-to-back words with no idling at all.
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 2);
    if (r < 96)
      return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued events on in_*, feeds the predictor on accept.
  // ---------------------------------------------------------------------------
  clock_event_t drive_event;
  int           in_gap   = 0;
  int           in_burst = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        drive_event.kind  = act_t'(in_tuser);
        drive_event.sel   = in_tdata[2:0];
        drive_event.value = in_tdata[10:3];
        expected_readouts = {expected_readouts, apply_event(drive_event)};
        events_accepted++;
      end
      // slot is free when nothing is presented or the current word just went
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          drive_event = pending_events.pop_front();
          in_tuser  <= drive_event.kind;
          in_tdata  <= {5'b00000, drive_event.value, drive_event.sel};
          in_tvalid <= 1'b1;
          in_gap    = pick_gap(in_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure on out_*, checks each result word in order.
  // ---------------------------------------------------------------------------
  clock_readout_t seen_readout;
  clock_readout_t want_readout;
  int             out_stall = 0;
  int             out_burst = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_readout = clock_readout_t'(out_tdata[46:0]);
        if (expected_readouts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing expected: %h", $time, out_tdata);
        end else begin
          want_readout = expected_readouts.pop_front();
          if (seen_readout !== want_readout) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: readout mismatch (exp/got) sec %h/%h min %h/%h hr %h/%h",
                       $time, want_readout.seconds, seen_readout.seconds,
                       want_readout.minutes, seen_readout.minutes,
                       want_readout.hours, seen_readout.hours);
              $display("  wday %h/%h ctl %h/%h flags(wk..qtr) %b/%b",
                       want_readout.weekday, seen_readout.weekday,
                       want_readout.control, seen_readout.control,
                       want_readout.flags, seen_readout.flags);
            end
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall = pick_gap(out_burst);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a stuck handshake on either side ends the run.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bcd_real_time_clock_registers test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  logic [7:0] ctl_pick;

  initial begin
    // Directed part. Clock stopped: tick with run clear raises nothing.
    push_event(ACT_TICK, REG_CONTROL, 8'h00);
    // spare selects are ignored but still answer with a word
    push_event(ACT_WRITE, SEL_SPARE_FIRST, 8'hFF);
    push_event(ACT_WRITE, SEL_SPARE_MID, 8'h00);
    push_event(ACT_WRITE, SEL_SPARE_LAST, 8'hAA);
    // 12-hour AM decode: 23 mod 12 -> 11
    push_event(ACT_WRITE, REG_HOURS, 8'h23);
    // run + 24-hour mode, hours reload as 23
    push_event(ACT_WRITE, REG_CONTROL, 8'hC0);
    push_event(ACT_WRITE, REG_SECONDS, 8'h59);
    push_event(ACT_WRITE, REG_MINUTES, 8'h59);
    // first counted tick raises every flag; fourth tick wraps into the next day
    push_ticks(4);
    // clamping on out-of-range BCD bytes
    push_event(ACT_WRITE, REG_SECONDS, 8'hFF);
    push_event(ACT_WRITE, REG_MINUTES, 8'hFF);
    push_event(ACT_WRITE, REG_HOURS, 8'hFF);
    // weekday byte is stored raw, counter unchanged until the next tick refresh
    push_event(ACT_WRITE, REG_WEEKDAY, 8'hFF);
    push_ticks(1);
    // run, 12-hour, PM: hour 11 PM -> 23, then through midnight in 12-hour mode
    push_event(ACT_WRITE, REG_CONTROL, 8'hA0);
    push_event(ACT_WRITE, REG_HOURS, 8'h11);
    push_ticks(4);
    // 12 AM (PM bit cleared by the midnight refresh) decodes to hour 0
    push_event(ACT_WRITE, REG_HOURS, 8'h12);
    // stopped with every other control bit set, then all clear
    push_event(ACT_WRITE, REG_CONTROL, 8'h7F);
    push_ticks(1);
    push_event(ACT_WRITE, REG_CONTROL, 8'h00);

    // Random part: mostly a control write, a time preset near a wrap point
    // and a run of ticks; the rest is unconstrained noise.
    while (pending_events.size() < RANDOM_TARGET) begin
      if ($urandom_range(0, 99) < 75) begin
        ctl_pick = 8'($urandom);
        if ($urandom_range(0, 9) != 0)
          ctl_pick[CTL_RUN] = 1'b1;
        push_event(ACT_WRITE, REG_CONTROL, ctl_pick);
        if ($urandom_range(0, 1))
          push_event(ACT_WRITE, REG_SECONDS, near_wrap(8'h59));
        if ($urandom_range(0, 1))
          push_event(ACT_WRITE, REG_MINUTES, near_wrap(8'h59));
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 2))
            0:       push_event(ACT_WRITE, REG_HOURS, near_wrap(8'h23));
            1:       push_event(ACT_WRITE, REG_HOURS, near_wrap(8'h12));
            default: push_event(ACT_WRITE, REG_HOURS, 8'($urandom));
          endcase
        end
        if ($urandom_range(0, 7) == 0)
          push_event(ACT_WRITE, REG_WEEKDAY, 8'($urandom));
        push_ticks($urandom_range(1, 24));
      end else begin
        push_event(act_t'($urandom_range(0, 1)), 3'($urandom), 8'($urandom));
      end
    end
    events_total = pending_events.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every event accepted and every result word checked
    while (!(events_accepted == events_total && expected_readouts.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("bcd_real_time_clock_registers test passed");
    end else begin
      $display("bcd_real_time_clock_registers test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bcdrtc_pkg.sv
rtl/bcdrtc_update.sv
rtl/bcd_real_time_clock_registers.sv
rtl/bcdrtc_checker.sv
tb/bcd_real_time_clock_registers_tb.sv
